/* hdl/aescbc_pkg.sv */
// aescbc_pkg: shared types, constants and byte- and block-level functions for the aes-128 cbc block
// used by aes128_cbc_cipher_top; no dependencies
package aescbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_LOAD,
    ST_ROUND,
    ST_DONE,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_DIR      = 3'd4;

  localparam logic [7:0] POLY = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? POLY : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits 127-8i downto 120-8i
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[c*4+w] = sbox(a[((c+w)%4)*4+w]);
    for (int c = 0; c < 4; c++) begin
      if (!last) begin
        r[127-8*(4*c+0) -: 8] = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        r[127-8*(4*c+1) -: 8] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
        r[127-8*(4*c+2) -: 8] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
        r[127-8*(4*c+3) -: 8] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
      end else begin
        for (int w = 0; w < 4; w++) r[127-8*(4*c+w) -: 8] = t[4*c+w];
      end
    end
    return r;
  endfunction

  // inverse shift and sub, no key, no mix
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [7:0] a [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
    r = '0;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        r[127-8*(((c+w)%4)*4+w) -: 8] = inv_sbox(a[c*4+w]);
    return r;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a [16];
    logic [7:0] x2, x4, x8;
    logic [7:0] m9 [16];
    logic [7:0] mb [16];
    logic [7:0] md [16];
    logic [7:0] me [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      a[i] = s[127-8*i -: 8];
      x2 = xtime(a[i]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[i] = x8 ^ a[i];
      mb[i] = x8 ^ x2 ^ a[i];
      md[i] = x8 ^ x4 ^ a[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    for (int c = 0; c < 4; c++) begin
      r[127-8*(4*c+0) -: 8] = me[4*c] ^ mb[4*c+1] ^ md[4*c+2] ^ m9[4*c+3];
      r[127-8*(4*c+1) -: 8] = m9[4*c] ^ me[4*c+1] ^ mb[4*c+2] ^ md[4*c+3];
      r[127-8*(4*c+2) -: 8] = md[4*c] ^ m9[4*c+1] ^ me[4*c+2] ^ mb[4*c+3];
      r[127-8*(4*c+3) -: 8] = mb[4*c] ^ md[4*c+1] ^ m9[4*c+2] ^ me[4*c+3];
    end
    return r;
  endfunction

  // one key expansion step: previous round key to the next
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

/* hdl/aes128_cbc_cipher_top.sv */
// aes128_cbc_cipher_top: aes-128 cbc encrypt/decrypt with pkcs7 pad and unpad
// depends on aescbc_pkg
//
// One 128-bit block per input transaction, one round per cycle through a single round
// unit. The eleven round keys live in a synchronous memory (one 128-bit row per round)
// and are read from its registered port ahead of each round. After reset, and once a run
// of key register writes ends, the key is expanded into that memory (ST_KEY), during
// which no input transaction is taken (configuration writes still are). An encrypt or
// decrypt block passes from acceptance through the initial key add (ST_LOAD), ten rounds
// (ST_ROUND) and a finish step (ST_DONE) before a result is offered; the first key row is
// read at the accepting edge. Unless a pad block follows, the block is back in idle in the
// cycle after the result is taken, and a new block is accepted only from idle; a full
// last block in encrypt mode runs the cipher twice and gives two result transactions. The
// result register holds the result until it is taken, so output stall only delays the
// next block. In decrypt mode the last result's valid_bytes gives the length after unpad.
module aes128_cbc_cipher_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        first_block,
  input  logic        last_block,
  input  logic [4:0]  byte_count,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic [4:0]  valid_bytes,
  output logic        end_of_message,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        cipher_direction;
  logic        key_dirty;

  // round key memory, one row per round
  logic [127:0] rk_mem [11];
  logic [127:0] rk_rd;
  logic [3:0]   rk_raddr;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;

  aescbc_pkg::state_t state, state_next;

  logic [127:0] chain;      // cbc chaining value
  logic [127:0] work;       // block inside the round loop
  logic [127:0] cipher_in;  // ciphertext of current decrypt block
  logic [3:0]   round;
  logic         dir;        // direction latched for this block
  logic         last;
  logic         pad_pending; // second cipher pass for a whole pad block
  logic [127:0] exp_key;    // expansion running key
  logic [7:0]   rcon;

  logic [127:0] in_blk;
  logic [4:0]   n_clip;
  logic [127:0] padded;
  logic [127:0] dec_plain;
  logic [7:0]   pad_val;
  logic [127:0] enc_next;
  logic [127:0] dec_next;

  // config writes; a key write schedules a new expansion, which starts
  // from idle once no write is in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      iv_high <= '0;
      iv_low <= '0;
      cipher_direction <= 1'b0;
      key_dirty <= 1'b1;
    end else begin
      if (state == aescbc_pkg::ST_IDLE && !cfg_we) key_dirty <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          aescbc_pkg::REG_KEY_HIGH: begin
            key_high <= cfg_data;
            key_dirty <= 1'b1;
          end
          aescbc_pkg::REG_KEY_LOW: begin
            key_low <= cfg_data;
            key_dirty <= 1'b1;
          end
          aescbc_pkg::REG_IV_HIGH: iv_high <= cfg_data;
          aescbc_pkg::REG_IV_LOW:  iv_low <= cfg_data;
          aescbc_pkg::REG_DIR:     cipher_direction <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // round key memory
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rd <= rk_mem[rk_raddr];
  end

  assign in_blk = {block_high, block_low};
  assign n_clip = (byte_count > 5'd16) ? 5'd16 : byte_count;

  // pkcs7 pad of the last encrypt block
  always_comb begin
    padded = in_blk;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= n_clip) padded[127-8*i -: 8] = 8'(5'd16 - n_clip);
    end
  end

  assign enc_next = aescbc_pkg::enc_round(work, round == 4'd10) ^ rk_rd;
  assign dec_next = (round == 4'd0) ? (aescbc_pkg::dec_sub(work) ^ rk_rd)
                                    : aescbc_pkg::inv_mix(aescbc_pkg::dec_sub(work) ^ rk_rd);
  assign dec_plain = work ^ chain;
  assign pad_val = dec_plain[7:0];

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    rk_raddr = round;
    rk_we = 1'b0;
    rk_waddr = round;
    rk_wdata = exp_key;
    unique case (state)
      aescbc_pkg::ST_IDLE: begin
        in_stall = key_dirty || cfg_we;
        if (key_dirty && !cfg_we) state_next = aescbc_pkg::ST_KEY;
        else if (in_valid && !cfg_we && !key_dirty) state_next = aescbc_pkg::ST_LOAD;
        rk_raddr = cipher_direction ? 4'd10 : 4'd0;
      end
      aescbc_pkg::ST_KEY: begin
        rk_we = 1'b1;
        if (round == 4'd10) state_next = aescbc_pkg::ST_IDLE;
      end
      aescbc_pkg::ST_LOAD: begin
        // initial key row is on rk_rd; fetch the first round row
        rk_raddr = dir ? 4'd9 : 4'd1;
        state_next = aescbc_pkg::ST_ROUND;
      end
      aescbc_pkg::ST_ROUND: begin
        rk_raddr = dir ? round - 4'd1 : round + 4'd1;
        if ((dir && round == 4'd0) || (!dir && round == 4'd10)) state_next = aescbc_pkg::ST_DONE;
      end
      aescbc_pkg::ST_DONE: begin
        rk_raddr = 4'd0;
        state_next = aescbc_pkg::ST_OUT;
      end
      aescbc_pkg::ST_OUT: begin
        rk_raddr = 4'd0;
        if (!out_stall) begin
          if (pad_pending) state_next = aescbc_pkg::ST_LOAD;
          else state_next = aescbc_pkg::ST_IDLE;
        end
      end
      default: state_next = aescbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= aescbc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
      chain <= '0;
      out_valid <= 1'b0;
      pad_pending <= 1'b0;
      exp_key <= '0;
      rcon <= 8'h01;
    end else begin
      unique case (state)
        aescbc_pkg::ST_IDLE: begin
          round <= '0;
          exp_key <= {key_high, key_low};
          rcon <= 8'h01;
          if (!key_dirty && in_valid && !cfg_we) begin
            dir <= cipher_direction;
            last <= last_block;
            cipher_in <= in_blk;
            round <= cipher_direction ? 4'd10 : 4'd0;
            if (first_block) chain <= {iv_high, iv_low};
            if (cipher_direction) begin
              work <= in_blk;
              if (first_block) begin
                // chain updated above; decrypt uses iv at finish
              end
            end else begin
              // xor with chain happens at load
              work <= (last_block && n_clip != 5'd16) ? padded : in_blk;
            end
            pad_pending <= !cipher_direction && last_block && n_clip == 5'd16;
          end
        end
        aescbc_pkg::ST_KEY: begin
          exp_key <= aescbc_pkg::key_step(exp_key, rcon);
          rcon <= aescbc_pkg::xtime(rcon);
          round <= (round == 4'd10) ? 4'd0 : round + 4'd1;
        end
        aescbc_pkg::ST_LOAD: begin
          // initial key add; encrypt also folds in the chain
          work <= dir ? (work ^ rk_rd) : (work ^ chain ^ rk_rd);
          round <= dir ? 4'd9 : 4'd1;
        end
        aescbc_pkg::ST_ROUND: begin
          work <= dir ? dec_next : enc_next;
          if (!((dir && round == 4'd0) || (!dir && round == 4'd10)))
            round <= dir ? round - 4'd1 : round + 4'd1;
        end
        aescbc_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          if (dir) begin
            out_high <= dec_plain[127:64];
            out_low <= dec_plain[63:0];
            valid_bytes <= (last && pad_val >= 8'd1 && pad_val <= 8'd16)
                           ? 5'(8'd16 - pad_val) : 5'd16;
            end_of_message <= last;
            chain <= cipher_in;
          end else begin
            out_high <= work[127:64];
            out_low <= work[63:0];
            valid_bytes <= 5'd16;
            end_of_message <= last && !pad_pending;
            chain <= work;
          end
        end
        aescbc_pkg::ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (pad_pending) begin
              // whole pad block follows a full last block
              work <= {16{8'h10}};
              pad_pending <= 1'b0;
              round <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
